// ===== design/vfc_pkg.sv =====
package vfc_pkg;

   // Register map, one word per register
   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;

   typedef enum logic [2:0] {
      REG_TEMP_SETPOINT     = 3'd0,
      REG_HUMIDITY_SETPOINT = 3'd1,
      REG_ON_THRESHOLD      = 3'd2,
      REG_OFF_THRESHOLD     = 3'd3,
      REG_STARTUP_TICKS     = 3'd4,
      REG_GAIN              = 3'd5,
      REG_DUTY_MIN          = 3'd6,
      REG_DUTY_MAX          = 3'd7
   } reg_index_type;

   // Reset values of the registers
   localparam logic [7:0]  TempSetpointReset     = 8'd35;
   localparam logic [7:0]  HumiditySetpointReset = 8'd60;
   localparam logic [11:0] OnThresholdReset      = 12'd60;
   localparam logic [11:0] OffThresholdReset     = 12'd10;
   localparam logic [15:0] StartupTicksReset     = 16'd2000;
   localparam logic [7:0]  GainReset             = 8'd50;
   localparam logic [9:0]  DutyMinReset          = 10'd300;
   localparam logic [9:0]  DutyMaxReset          = 10'd1000;

   // Duty must move by at least this much before it is rewritten
   localparam int DutyHyst = 15;

   // x/20 = (x>>2)/5, and y/5 = (y*3277)>>14, exact for y below 16384
   localparam int RecipFive = 3277;
   localparam int RecipShift = 14;

   // Depth of the queue between front and back
   localparam int QueueDepth = 2;

   typedef struct packed {
      logic signed [11:0] temperature_tenths;
      logic [9:0]         humidity_tenths;
   } req_type;

   typedef struct packed {
      logic       fan_on;
      logic [9:0] duty;
      logic       drive_written;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  temp_setpoint;
      logic [7:0]  humidity_setpoint;
      logic [11:0] on_threshold;
      logic [11:0] off_threshold;
      logic [15:0] startup_ticks;
      logic [7:0]  gain;
      logic [9:0]  duty_min;
      logic [9:0]  duty_max;
   } cfg_type;

   // Classified tick, handed from front to back
   typedef struct packed {
      logic       above_on;
      logic       below_off;
      logic [9:0] cand;
   } job_type;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'b001,
      PH_STARTING = 3'b010,
      PH_ACTIVE   = 3'b100
   } phase_type;

endpackage

// ===== design/vfc_csr.sv =====
module vfc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [vfc_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [vfc_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [vfc_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                               csr_pready,
   output vfc_pkg::cfg_type                   cfg
);

   vfc_pkg::cfg_type      cfg_ff;
   vfc_pkg::cfg_type      cfg_in;
   vfc_pkg::reg_index_type index;
   logic                  wr_en;

   assign index = vfc_pkg::reg_index_type'(csr_paddr[4:2]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            vfc_pkg::REG_TEMP_SETPOINT:     cfg_in.temp_setpoint     = csr_pwdata[7:0];
            vfc_pkg::REG_HUMIDITY_SETPOINT: cfg_in.humidity_setpoint = csr_pwdata[7:0];
            vfc_pkg::REG_ON_THRESHOLD:      cfg_in.on_threshold      = csr_pwdata[11:0];
            vfc_pkg::REG_OFF_THRESHOLD:     cfg_in.off_threshold     = csr_pwdata[11:0];
            vfc_pkg::REG_STARTUP_TICKS:     cfg_in.startup_ticks     = csr_pwdata[15:0];
            vfc_pkg::REG_GAIN:              cfg_in.gain              = csr_pwdata[7:0];
            vfc_pkg::REG_DUTY_MIN:          cfg_in.duty_min          = csr_pwdata[9:0];
            vfc_pkg::REG_DUTY_MAX:          cfg_in.duty_max          = csr_pwdata[9:0];
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temp_setpoint     <= vfc_pkg::TempSetpointReset;
         cfg_ff.humidity_setpoint <= vfc_pkg::HumiditySetpointReset;
         cfg_ff.on_threshold      <= vfc_pkg::OnThresholdReset;
         cfg_ff.off_threshold     <= vfc_pkg::OffThresholdReset;
         cfg_ff.startup_ticks     <= vfc_pkg::StartupTicksReset;
         cfg_ff.gain              <= vfc_pkg::GainReset;
         cfg_ff.duty_min          <= vfc_pkg::DutyMinReset;
         cfg_ff.duty_max          <= vfc_pkg::DutyMaxReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      case (index)
         vfc_pkg::REG_TEMP_SETPOINT:     csr_prdata = 32'(cfg_ff.temp_setpoint);
         vfc_pkg::REG_HUMIDITY_SETPOINT: csr_prdata = 32'(cfg_ff.humidity_setpoint);
         vfc_pkg::REG_ON_THRESHOLD:      csr_prdata = 32'(cfg_ff.on_threshold);
         vfc_pkg::REG_OFF_THRESHOLD:     csr_prdata = 32'(cfg_ff.off_threshold);
         vfc_pkg::REG_STARTUP_TICKS:     csr_prdata = 32'(cfg_ff.startup_ticks);
         vfc_pkg::REG_GAIN:              csr_prdata = 32'(cfg_ff.gain);
         vfc_pkg::REG_DUTY_MIN:          csr_prdata = 32'(cfg_ff.duty_min);
         vfc_pkg::REG_DUTY_MAX:          csr_prdata = 32'(cfg_ff.duty_max);
         default:                        csr_prdata = '0;
      endcase
   end

endmodule

// ===== design/vfc_front.sv =====
module vfc_front (
   input  logic              clock,
   input  logic              reset,
   input  vfc_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  vfc_pkg::req_type  req_item,
   output logic              job_valid,
   input  logic              job_stall,
   output vfc_pkg::job_type  job_item
);

   // Stage valids
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic s4_valid_ff, s4_valid_in;
   logic s1_load, s2_load, s3_load, s4_load;

   // Stage payloads
   logic signed [15:0] demand_ff, demand_in;
   logic               neg2_ff, neg2_in;
   logic               above2_ff, above2_in;
   logic               below2_ff, below2_in;
   logic [8:0]         quot_ff, quot_in;
   logic               neg3_ff;
   logic               above3_ff;
   logic               below3_ff;
   logic [16:0]        raw_ff, raw_in;
   vfc_pkg::job_type   job_ff, job_in;

   logic signed [15:0] temp_ext, hum_ext, temp_ref, hum_ref;
   logic signed [15:0] dt, dh;
   logic signed [15:0] excess;
   logic [10:0]        quarter;
   logic [22:0]        prod;
   logic [9:0]         capped;

   // A stage loads when it is empty or its successor moves on
   assign s4_load = !s4_valid_ff || !job_stall;
   assign s3_load = !s3_valid_ff || s4_load;
   assign s2_load = !s2_valid_ff || s3_load;
   assign s1_load = !s1_valid_ff || s2_load;
   assign req_stall = !s1_load;

   assign s1_valid_in = s1_load ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_load ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_load ? s2_valid_ff : s3_valid_ff;
   assign s4_valid_in = s4_load ? s3_valid_ff : s4_valid_ff;

   // Stage 1: demand in twentieths, 2*dT + 3*dH
   assign temp_ext = 16'(req_item.temperature_tenths);
   assign hum_ext  = $signed({6'd0, req_item.humidity_tenths});
   assign temp_ref = $signed({5'd0, cfg.temp_setpoint, 3'd0})
                   + $signed({7'd0, cfg.temp_setpoint, 1'd0});
   assign hum_ref  = $signed({5'd0, cfg.humidity_setpoint, 3'd0})
                   + $signed({7'd0, cfg.humidity_setpoint, 1'd0});
   assign dt = temp_ext - temp_ref;
   assign dh = hum_ext - hum_ref;
   assign demand_in = (dt <<< 1) + (dh <<< 1) + dh;

   // Stage 2: threshold compares and excess/20
   assign excess    = demand_ff - $signed({4'd0, cfg.on_threshold});
   assign neg2_in   = excess[15];
   assign above2_in = demand_ff > $signed({4'd0, cfg.on_threshold});
   assign below2_in = demand_ff < $signed({4'd0, cfg.off_threshold});
   assign quarter   = excess[12:2];
   assign prod      = 23'(quarter) * 23'(vfc_pkg::RecipFive);
   assign quot_in   = prod[22:vfc_pkg::RecipShift];

   // Stage 3: scale by gain
   assign raw_in = 17'(quot_ff) * 17'(cfg.gain);

   // Stage 4: clamp, max first then min
   assign capped = (raw_ff > 17'(cfg.duty_max)) ? cfg.duty_max : raw_ff[9:0];
   always_comb begin
      job_in.above_on  = above3_ff;
      job_in.below_off = below3_ff;
      if (neg3_ff || (capped < cfg.duty_min)) begin
         job_in.cand = cfg.duty_min;
      end else begin
         job_in.cand = capped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         demand_ff <= demand_in;
      end
      if (s2_load) begin
         neg2_ff   <= neg2_in;
         above2_ff <= above2_in;
         below2_ff <= below2_in;
         quot_ff   <= quot_in;
      end
      if (s3_load) begin
         neg3_ff   <= neg2_ff;
         above3_ff <= above2_ff;
         below3_ff <= below2_ff;
         raw_ff    <= raw_in;
      end
      if (s4_load) begin
         job_ff <= job_in;
      end
   end

   assign job_valid = s4_valid_ff;
   assign job_item  = job_ff;

endmodule

// ===== design/vfc_queue.sv =====
module vfc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_stall,
   input  vfc_pkg::job_type  push_item,
   output logic              pop_valid,
   input  logic              pop_stall,
   output vfc_pkg::job_type  pop_item
);

   localparam int PtrWidth = $clog2(vfc_pkg::QueueDepth);
   localparam int CntWidth = $clog2(vfc_pkg::QueueDepth + 1);

   vfc_pkg::job_type      entry_ff [vfc_pkg::QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  full, empty, push, pop;

   assign full  = (count_ff == CntWidth'(vfc_pkg::QueueDepth));
   assign empty = (count_ff == '0);
   assign push_stall = full;
   assign pop_valid  = !empty;
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push = push_valid && !full;
   assign pop  = !empty && !pop_stall;

   // Pointer wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(vfc_pkg::QueueDepth - 1)) ? '0
                   : wr_ptr_ff + PtrWidth'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(vfc_pkg::QueueDepth - 1)) ? '0
                   : rd_ptr_ff + PtrWidth'(1);
      end
      count_in = count_ff + CntWidth'(push) - CntWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Occupancy never exceeds the depth
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntWidth'(vfc_pkg::QueueDepth))
      else $error("queue occupancy above depth");

   // Occupancy tracks the handshakes of the previous cycle
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff == $past(count_ff) + CntWidth'($past(push))
                                   - CntWidth'($past(pop)))
      else $error("queue count out of step with push and pop");

endmodule

// ===== design/vfc_back.sv =====
module vfc_back (
   input  logic              clock,
   input  logic              reset,
   input  vfc_pkg::cfg_type  cfg,
   input  logic              job_valid,
   output logic              job_stall,
   input  vfc_pkg::job_type  job_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output vfc_pkg::rsp_type  rsp_item
);

   vfc_pkg::phase_type phase_ff, phase_in;
   logic [15:0]        start_count_ff, start_count_in;
   logic [9:0]         duty_now_ff, duty_now_in;
   logic               fan_running_ff, fan_running_in;
   logic               rsp_valid_ff, rsp_valid_in;
   vfc_pkg::rsp_type   rsp_item_ff, rsp_item_in;

   logic               take;
   logic               written;
   logic signed [10:0] diff;
   logic [10:0]        mag;
   logic               moved;

   // Take a job whenever the output register is free or being emptied
   assign take = job_valid && (!rsp_valid_ff || !rsp_stall);
   assign job_stall = !(!rsp_valid_ff || !rsp_stall);

   // Hysteresis on duty changes
   assign diff  = $signed({1'b0, job_item.cand}) - $signed({1'b0, duty_now_ff});
   assign mag   = diff[10] ? 11'(-diff) : 11'(diff);
   assign moved = mag >= 11'(vfc_pkg::DutyHyst);

   // Phase controller
   always_comb begin
      phase_in       = phase_ff;
      start_count_in = start_count_ff;
      duty_now_in    = duty_now_ff;
      fan_running_in = fan_running_ff;
      written        = 1'b0;
      case (phase_ff)
         vfc_pkg::PH_IDLE: begin
            if (job_item.above_on) begin
               start_count_in = cfg.startup_ticks;
               phase_in       = vfc_pkg::PH_STARTING;
               duty_now_in    = cfg.duty_max;
               fan_running_in = 1'b1;
               written        = 1'b1;
            end
         end
         vfc_pkg::PH_STARTING: begin
            if (start_count_ff == '0) begin
               phase_in = vfc_pkg::PH_ACTIVE;
            end else begin
               start_count_in = start_count_ff - 16'd1;
            end
         end
         vfc_pkg::PH_ACTIVE: begin
            if (job_item.below_off) begin
               fan_running_in = 1'b0;
               duty_now_in    = '0;
               phase_in       = vfc_pkg::PH_IDLE;
               written        = 1'b1;
            end else if (moved) begin
               duty_now_in    = job_item.cand;
               fan_running_in = 1'b1;
               written        = 1'b1;
            end
         end
         default: begin
            start_count_in = '0;
            phase_in       = vfc_pkg::PH_IDLE;
         end
      endcase
      rsp_item_in.fan_on        = fan_running_in;
      rsp_item_in.duty          = duty_now_in;
      rsp_item_in.drive_written = written;
   end

   assign rsp_valid_in = take ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= vfc_pkg::PH_IDLE;
         start_count_ff <= '0;
         duty_now_ff    <= '0;
         fan_running_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff       <= phase_in;
            start_count_ff <= start_count_in;
            duty_now_ff    <= duty_now_in;
            fan_running_ff <= fan_running_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // A stopped fan always reports zero duty
   a_off_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_item_ff.fan_on |-> rsp_item_ff.duty == '0)
      else $error("fan reported off with non-zero duty");

   // Idle means the fan is stopped; start-up means it runs
   a_idle_stopped: assert property (@(posedge clock) disable iff (reset)
      phase_ff == vfc_pkg::PH_IDLE |-> !fan_running_ff && duty_now_ff == '0)
      else $error("fan running while idle");

   a_start_running: assert property (@(posedge clock) disable iff (reset)
      phase_ff == vfc_pkg::PH_STARTING |-> fan_running_ff)
      else $error("fan stopped during start-up");

endmodule

// ===== design/ventilation_fan_controller.sv =====
// Ventilation fan controller. Each req transaction carries one sensor tick
// (temperature and humidity in tenths) and produces exactly one rsp
// transaction with the fan state, the current duty and a flag set when the
// tick issued a new drive command. One tick is accepted every clock cycle
// while req_stall is low. Its result passes through six registers before
// it appears on rsp: the four-stage classification pipeline (demand,
// excess/20, gain multiply, clamp), whose first stage loads at the accepting
// edge, one entry of the queue, and the phase controller's output register.
// A two-entry queue between pipeline and controller lets each side stall
// independently. Registers sit on a zero-wait-state APB-style port at byte
// address 4*i and should be written only while no tick is in flight.
module ventilation_fan_controller (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  vfc_pkg::req_type                   req_item,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output vfc_pkg::rsp_type                   rsp_item,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [vfc_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [vfc_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [vfc_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                               csr_pready
);

   vfc_pkg::cfg_type cfg;
   logic             front_valid, front_stall;
   vfc_pkg::job_type front_item;
   logic             back_valid, back_stall;
   vfc_pkg::job_type back_item;

   // Register file
   vfc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Classification pipeline
   vfc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .job_valid (front_valid),
      .job_stall (front_stall),
      .job_item  (front_item)
   );

   // Decoupling queue
   vfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_stall (front_stall),
      .push_item  (front_item),
      .pop_valid  (back_valid),
      .pop_stall  (back_stall),
      .pop_item   (back_item)
   );

   // Phase controller and output register
   vfc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .job_valid (back_valid),
      .job_stall (back_stall),
      .job_item  (back_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
